// ===== sv/hsa_pkg.sv =====
`timescale 1ns / 1ps
package hsa_pkg;
  localparam int FRAC_W = 16;
  localparam int QW = FRAC_W + 1;
  localparam int GAIN_W = 12;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd256;
  localparam logic [QW-1:0] FRAC_ONE = 17'd65536;
  localparam logic [19:0] HUE_SPAN = 20'd393216;
  localparam logic [19:0] HUE_GREEN = 20'd131072;
  localparam logic [19:0] HUE_BLUE = 20'd262144;
  localparam int NCELLS = QW;

  typedef logic [1:0] sel_t;
  localparam sel_t SEL_RED = 2'd0;
  localparam sel_t SEL_GREEN = 2'd1;
  localparam sel_t SEL_BLUE = 2'd2;

  localparam logic [2:0] SEXT_0 = 3'd0;
  localparam logic [2:0] SEXT_1 = 3'd1;
  localparam logic [2:0] SEXT_2 = 3'd2;
  localparam logic [2:0] SEXT_3 = 3'd3;
  localparam logic [2:0] SEXT_4 = 3'd4;

  typedef struct packed {
    logic gray;
    sel_t sel;
    logic neg;
  } pix_ctl_t;
endpackage

// ===== sv/hsa_if.sv =====
`timescale 1ns / 1ps
interface hsa_pix_if #(parameter int CB = 8);
  logic valid;
  logic ready;
  logic [CB-1:0] red;
  logic [CB-1:0] green;
  logic [CB-1:0] blue;
  logic [CB-1:0] alpha;
  modport source(output valid, red, green, blue, alpha, input ready);
  modport sink(input valid, red, green, blue, alpha, output ready);
endinterface

interface hsa_cfg_if;
  logic valid;
  logic ready;
  logic [hsa_pkg::GAIN_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== sv/hsa_front.sv =====
`timescale 1ns / 1ps
module hsa_front #(
  parameter int CB = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  logic [CB-1:0] r,
  input  logic [CB-1:0] g,
  input  logic [CB-1:0] b,
  input  logic [CB-1:0] a,
  output logic valid_r,
  output logic [CB-1:0] r_r,
  output logic [CB-1:0] g_r,
  output logic [CB-1:0] b_r,
  output logic [CB-1:0] a_r,
  output logic [CB-1:0] mx_r,
  output hsa_pkg::pix_ctl_t ctl_r,
  output logic [CB-1:0] hden_r,
  output logic [CB-1:0] hrem_r,
  output logic [hsa_pkg::QW-1:0] hlow_r,
  output logic [CB-1:0] sden_r,
  output logic [CB-1:0] srem_r,
  output logic [hsa_pkg::QW-1:0] slow_r
);
  localparam int NW = CB + hsa_pkg::QW;

  logic [CB-1:0] mx, mn, delta, ha, hb, mag;
  hsa_pkg::sel_t sel;
  logic [NW-1:0] hnum, snum;

  always_comb begin
    if (r >= g && r >= b) begin
      sel = hsa_pkg::SEL_RED;
      mx = r;
      ha = g;
      hb = b;
    end else if (g >= b) begin
      sel = hsa_pkg::SEL_GREEN;
      mx = g;
      ha = b;
      hb = r;
    end else begin
      sel = hsa_pkg::SEL_BLUE;
      mx = b;
      ha = r;
      hb = g;
    end
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    mag = (ha >= hb) ? ha - hb : hb - ha;
    hnum = {1'b0, mag, {hsa_pkg::FRAC_W{1'b0}}} + NW'(delta >> 1);
    snum = {1'b0, delta, {hsa_pkg::FRAC_W{1'b0}}} + NW'(mx >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r;
      g_r <= g;
      b_r <= b;
      a_r <= a;
      mx_r <= mx;
      ctl_r.gray <= (delta == '0);
      ctl_r.sel <= sel;
      ctl_r.neg <= (ha < hb);
      hden_r <= delta;
      hrem_r <= hnum[NW-1:hsa_pkg::QW];
      hlow_r <= hnum[hsa_pkg::QW-1:0];
      sden_r <= mx;
      srem_r <= snum[NW-1:hsa_pkg::QW];
      slow_r <= snum[hsa_pkg::QW-1:0];
    end
  end
endmodule

// ===== sv/hsa_div_cell.sv =====
`timescale 1ns / 1ps
module hsa_div_cell #(
  parameter int CB = 8,
  parameter int SW = 44
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic valid_i,
  input  logic [SW-1:0] side_i,
  input  logic [CB-1:0] den_i [2],
  input  logic [CB-1:0] rem_i [2],
  input  logic [hsa_pkg::QW-1:0] low_i [2],
  input  logic [hsa_pkg::QW-1:0] q_i [2],
  output logic valid_r,
  output logic [SW-1:0] side_r,
  output logic [CB-1:0] den_r [2],
  output logic [CB-1:0] rem_r [2],
  output logic [hsa_pkg::QW-1:0] low_r [2],
  output logic [hsa_pkg::QW-1:0] q_r [2]
);
  // One restoring division step for each of the two lanes (hue, saturation).
  logic [CB:0] trial [2];
  logic take [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i] = {rem_i[i], low_i[i][hsa_pkg::QW-1]};
      take[i] = (trial[i] >= {1'b0, den_i[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_i;
      for (int i = 0; i < 2; i++) begin
        den_r[i] <= den_i[i];
        rem_r[i] <= take[i] ? CB'(trial[i] - {1'b0, den_i[i]}) : trial[i][CB-1:0];
        low_r[i] <= {low_i[i][hsa_pkg::QW-2:0], 1'b0};
        q_r[i] <= {q_i[i][hsa_pkg::QW-2:0], take[i]};
      end
    end
  end
endmodule

// ===== sv/hsa_rebuild.sv =====
`timescale 1ns / 1ps
module hsa_rebuild #(
  parameter int CB = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic [hsa_pkg::GAIN_W-1:0] gain,
  input  logic valid_i,
  input  logic [CB-1:0] r_i,
  input  logic [CB-1:0] g_i,
  input  logic [CB-1:0] b_i,
  input  logic [CB-1:0] a_i,
  input  logic [CB-1:0] mx_i,
  input  hsa_pkg::pix_ctl_t ctl_i,
  input  logic [hsa_pkg::QW-1:0] qh_i,
  input  logic [hsa_pkg::QW-1:0] qs_i,
  output logic valid_r,
  output logic [CB-1:0] r_r,
  output logic [CB-1:0] g_r,
  output logic [CB-1:0] b_r,
  output logic [CB-1:0] a_r
);
  localparam int QW = hsa_pkg::QW;
  localparam int PW = QW + hsa_pkg::GAIN_W;
  localparam int MW = CB + QW;
  localparam int XW = MW + QW;
  localparam int SUMW = CB + 34;
  localparam logic [CB+1:0] CH_MAX = {2'b00, {CB{1'b1}}};

  // Stage 1: hue wrap, sextant, saturation times gain.
  logic [19:0] base, hue_sum, hue;
  logic [2:0] sext1;
  logic [QW-1:0] f1;
  logic [PW-1:0] prod1;

  always_comb begin
    case (ctl_i.sel)
      hsa_pkg::SEL_RED: base = '0;
      hsa_pkg::SEL_GREEN: base = hsa_pkg::HUE_GREEN;
      default: base = hsa_pkg::HUE_BLUE;
    endcase
    hue_sum = ctl_i.neg ? base + hsa_pkg::HUE_SPAN - {3'b000, qh_i} : base + {3'b000, qh_i};
    hue = (hue_sum >= hsa_pkg::HUE_SPAN) ? hue_sum - hsa_pkg::HUE_SPAN : hue_sum;
    sext1 = hue[18:16];
    f1 = sext1[0] ? hsa_pkg::FRAC_ONE - {1'b0, hue[15:0]} : {1'b0, hue[15:0]};
    prod1 = PW'(qs_i) * PW'(gain);
  end

  logic v1_r, v2_r, v3_r;
  logic [4*CB-1:0] px1_r, px2_r, px3_r;
  logic [CB-1:0] mx1_r, mx2_r, mx3_r;
  logic gray1_r, gray2_r, gray3_r;
  logic [2:0] sext1_r, sext2_r, sext3_r;
  logic [QW-1:0] f1_r, f2_r;
  logic [PW-1:0] prod1_r;
  logic [MW-1:0] ms2_r, ms3_r;
  logic [XW-1:0] xx3_r;

  // Stage 2: rounded, clamped saturation times value.
  logic [PW-PW+PW-8:0] s2_full;
  logic [QW-1:0] s2;
  always_comb begin
    s2_full = (PW - 7)'((prod1_r + PW'(128)) >> 8);
    s2 = (s2_full > (PW - 7)'(hsa_pkg::FRAC_ONE)) ? hsa_pkg::FRAC_ONE : s2_full[QW-1:0];
  end

  // Stage 4: channel rebuild at scale 2^32.
  logic [SUMW-1:0] cc, xx, mm, pr, pg, pb;
  logic [CB+1:0] chr, chg, chb;
  always_comb begin
    cc = SUMW'(ms3_r) << 16;
    xx = SUMW'(xx3_r);
    mm = (SUMW'(mx3_r) << 32) - cc;
    case (sext3_r)
      hsa_pkg::SEXT_0: begin pr = cc; pg = xx; pb = '0; end
      hsa_pkg::SEXT_1: begin pr = xx; pg = cc; pb = '0; end
      hsa_pkg::SEXT_2: begin pr = '0; pg = cc; pb = xx; end
      hsa_pkg::SEXT_3: begin pr = '0; pg = xx; pb = cc; end
      hsa_pkg::SEXT_4: begin pr = xx; pg = '0; pb = cc; end
      default: begin pr = cc; pg = '0; pb = xx; end
    endcase
    chr = (CB + 2)'((pr + mm + (SUMW'(1) << 31)) >> 32);
    chg = (CB + 2)'((pg + mm + (SUMW'(1) << 31)) >> 32);
    chb = (CB + 2)'((pb + mm + (SUMW'(1) << 31)) >> 32);
    if (chr > CH_MAX) chr = CH_MAX;
    if (chg > CH_MAX) chg = CH_MAX;
    if (chb > CH_MAX) chb = CH_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      valid_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r <= {r_i, g_i, b_i, a_i};
      mx1_r <= mx_i;
      gray1_r <= ctl_i.gray;
      sext1_r <= sext1;
      f1_r <= f1;
      prod1_r <= prod1;

      px2_r <= px1_r;
      mx2_r <= mx1_r;
      gray2_r <= gray1_r;
      sext2_r <= sext1_r;
      f2_r <= f1_r;
      ms2_r <= MW'(mx1_r) * MW'(s2);

      px3_r <= px2_r;
      mx3_r <= mx2_r;
      gray3_r <= gray2_r;
      sext3_r <= sext2_r;
      ms3_r <= ms2_r;
      xx3_r <= XW'(ms2_r) * XW'(f2_r);

      a_r <= px3_r[CB-1:0];
      if (gray3_r) begin
        r_r <= px3_r[4*CB-1:3*CB];
        g_r <= px3_r[3*CB-1:2*CB];
        b_r <= px3_r[2*CB-1:CB];
      end else begin
        r_r <= chr[CB-1:0];
        g_r <= chg[CB-1:0];
        b_r <= chb[CB-1:0];
      end
    end
  end
endmodule

// ===== sv/hsv_saturation_adjust.sv =====
`timescale 1ns / 1ps
// Pipeline from an input beat to its result beat: one input register,
// seventeen divider cells, four rebuild stages ending in the output register.
// Throughput: one pixel per cycle; the whole pipeline holds only while the
// output register is full and not taken. No clearing pass after reset.
// Reset: rst_n (synchronous, active low) empties the pipeline and sets the
// saturation gain to 1.0 (256).
module hsv_saturation_adjust #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  hsa_pix_if.sink in_pix,
  hsa_pix_if.source out_pix,
  hsa_cfg_if.sink cfg_wr
);
  localparam int CB = CHANNEL_BITS;
  localparam int QW = hsa_pkg::QW;
  localparam int N = hsa_pkg::NCELLS;
  localparam int SW = 5 * CB + 4;

  logic [hsa_pkg::GAIN_W-1:0] gain_r;
  logic en;

  assign cfg_wr.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= hsa_pkg::GAIN_RESET;
    end else if (cfg_wr.valid) begin
      gain_r <= cfg_wr.data;
    end
  end

  assign en = !out_pix.valid || out_pix.ready;
  assign in_pix.ready = en;

  logic fv;
  logic [CB-1:0] fr, fg, fb, fa, fmx;
  hsa_pkg::pix_ctl_t fctl;
  logic [CB-1:0] hden, hrem, sden, srem;
  logic [QW-1:0] hlow, slow;

  hsa_front #(.CB(CB)) u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_pix.valid),
    .r(in_pix.red), .g(in_pix.green), .b(in_pix.blue), .a(in_pix.alpha),
    .valid_r(fv), .r_r(fr), .g_r(fg), .b_r(fb), .a_r(fa), .mx_r(fmx), .ctl_r(fctl),
    .hden_r(hden), .hrem_r(hrem), .hlow_r(hlow),
    .sden_r(sden), .srem_r(srem), .slow_r(slow)
  );

  logic v [N+1];
  logic [SW-1:0] side [N+1];
  logic [CB-1:0] den [N+1][2];
  logic [CB-1:0] rem [N+1][2];
  logic [QW-1:0] low [N+1][2];
  logic [QW-1:0] q [N+1][2];

  assign v[0] = fv;
  assign side[0] = {fr, fg, fb, fa, fmx, fctl};
  assign den[0][0] = hden;
  assign den[0][1] = sden;
  assign rem[0][0] = hrem;
  assign rem[0][1] = srem;
  assign low[0][0] = hlow;
  assign low[0][1] = slow;
  assign q[0][0] = '0;
  assign q[0][1] = '0;

  for (genvar k = 0; k < N; k++) begin : g_cell
    hsa_div_cell #(.CB(CB), .SW(SW)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(v[k]), .side_i(side[k]), .den_i(den[k]), .rem_i(rem[k]),
      .low_i(low[k]), .q_i(q[k]),
      .valid_r(v[k+1]), .side_r(side[k+1]), .den_r(den[k+1]), .rem_r(rem[k+1]),
      .low_r(low[k+1]), .q_r(q[k+1])
    );
  end

  hsa_pkg::pix_ctl_t lctl;
  assign lctl = side[N][3:0];

  hsa_rebuild #(.CB(CB)) u_rebuild (
    .clk(clk), .rst_n(rst_n), .en(en), .gain(gain_r),
    .valid_i(v[N]),
    .r_i(side[N][5*CB+3:4*CB+4]), .g_i(side[N][4*CB+3:3*CB+4]),
    .b_i(side[N][3*CB+3:2*CB+4]), .a_i(side[N][2*CB+3:CB+4]),
    .mx_i(side[N][CB+3:4]), .ctl_i(lctl),
    .qh_i(q[N][0]), .qs_i(q[N][1]),
    .valid_r(out_pix.valid), .r_r(out_pix.red), .g_r(out_pix.green),
    .b_r(out_pix.blue), .a_r(out_pix.alpha)
  );
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  logic clk;
  logic rst_n;

  hsa_pix_if #(.CB(8)) in_pix();
  hsa_pix_if #(.CB(8)) out_pix();
  hsa_cfg_if cfg_wr();

  hsv_saturation_adjust #(.CHANNEL_BITS(8)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_pix(in_pix.sink),
    .out_pix(out_pix.source),
    .cfg_wr(cfg_wr.sink)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  pixel_t pending_pixels[$];
  pixel_t expected_pixels[$];
  logic [hsa_pkg::GAIN_W-1:0] gain_model;
  int mismatch_count;
  int pixels_sent;
  int pixels_checked;
  int gray_seen;
  bit idle_enable;
  bit sender_hold;
  int send_gap;
  int take_gap;

  // Rounded |num| * 65536 / den.
  function automatic logic [31:0] ratio_q16(input logic [31:0] num, input logic [31:0] den);
    logic [63:0] wide;
    wide = ({32'd0, num} << 16) + {33'd0, den[31:1]};
    return 32'(wide / den);
  endfunction

  function automatic logic [7:0] channel_round(input logic [63:0] part, input logic [63:0] base);
    logic [63:0] sum;
    sum = (part + base + 64'h8000_0000) >> 32;
    return (sum > 64'd255) ? 8'hFF : sum[7:0];
  endfunction

  function automatic pixel_t saturate_pixel(input pixel_t px,
                                            input logic [hsa_pkg::GAIN_W-1:0] gain);
    logic [31:0] r, g, b, mx, mn, delta, hue, sat, frac, f;
    logic [2:0] sext;
    logic [63:0] s2, cc, xx, mm, pr, pg, pb;
    pixel_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    res = px;
    if (delta == 0) return res;
    if (mx == r) begin
      hue = (g >= b) ? ratio_q16(g - b, delta)
                     : hsa_pkg::HUE_SPAN - ratio_q16(b - g, delta);
    end else if (mx == g) begin
      hue = (b >= r) ? hsa_pkg::HUE_GREEN + ratio_q16(b - r, delta)
                     : hsa_pkg::HUE_GREEN + hsa_pkg::HUE_SPAN - ratio_q16(r - b, delta);
    end else begin
      hue = (r >= g) ? hsa_pkg::HUE_BLUE + ratio_q16(r - g, delta)
                     : hsa_pkg::HUE_BLUE + hsa_pkg::HUE_SPAN - ratio_q16(g - r, delta);
    end
    hue = hue % hsa_pkg::HUE_SPAN;
    sext = hue[18:16];
    frac = {16'd0, hue[15:0]};
    sat = ratio_q16(delta, mx);
    s2 = ({32'd0, sat} * gain + 64'd128) >> 8;
    if (s2 > hsa_pkg::FRAC_ONE) s2 = hsa_pkg::FRAC_ONE;
    f = sext[0] ? (hsa_pkg::FRAC_ONE - frac) : frac;
    cc = ({32'd0, mx} * s2) << 16;
    xx = {32'd0, mx} * s2 * f;
    mm = ({32'd0, mx} << 32) - cc;
    case (sext)
      hsa_pkg::SEXT_0: begin pr = cc; pg = xx; pb = 0; end
      hsa_pkg::SEXT_1: begin pr = xx; pg = cc; pb = 0; end
      hsa_pkg::SEXT_2: begin pr = 0; pg = cc; pb = xx; end
      hsa_pkg::SEXT_3: begin pr = 0; pg = xx; pb = cc; end
      hsa_pkg::SEXT_4: begin pr = xx; pg = 0; pb = cc; end
      default: begin pr = cc; pg = 0; pb = xx; end
    endcase
    res.red = channel_round(pr, mm);
    res.green = channel_round(pg, mm);
    res.blue = channel_round(pb, mm);
    return res;
  endfunction

  // Driver: one beat per accepted pixel, with random idle bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_pix.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_pix.valid && in_pix.ready) begin
        expected_pixels.push_back(saturate_pixel({in_pix.red, in_pix.green, in_pix.blue,
                                                  in_pix.alpha}, gain_model));
        pixels_sent <= pixels_sent + 1;
      end
      if (!in_pix.valid || in_pix.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_pix.valid <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 15);
          in_pix.valid <= 1'b0;
        end else if (!sender_hold && pending_pixels.size() > 0) begin
          pixel_t nxt;
          nxt = pending_pixels.pop_front();
          in_pix.valid <= 1'b1;
          in_pix.red <= nxt.red;
          in_pix.green <= nxt.green;
          in_pix.blue <= nxt.blue;
          in_pix.alpha <= nxt.alpha;
        end else begin
          in_pix.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor with random backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pix.ready <= 1'b0;
      take_gap <= 0;
    end else begin
      if (out_pix.valid && out_pix.ready) begin
        pixel_t got, want;
        got = {out_pix.red, out_pix.green, out_pix.blue, out_pix.alpha};
        if (expected_pixels.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) $display("unexpected output beat %h", got);
        end else begin
          want = expected_pixels.pop_front();
          pixels_checked <= pixels_checked + 1;
          if (got !== want) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
              $display("pixel mismatch: expected r=%0d g=%0d b=%0d a=%0d, got r=%0d g=%0d b=%0d a=%0d",
                       want.red, want.green, want.blue, want.alpha,
                       got.red, got.green, got.blue, got.alpha);
          end
        end
      end
      if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        out_pix.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        take_gap <= $urandom_range(0, 15);
        out_pix.ready <= 1'b0;
      end else begin
        out_pix.ready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (pending_pixels.size() > 0 || in_pix.valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_gain(input logic [hsa_pkg::GAIN_W-1:0] value);
    wait_drained();
    cfg_wr.data <= value;
    cfg_wr.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    cfg_wr.valid <= 1'b0;
    gain_model = value;
  endtask

  // Mostly colored pixels; a few grays and extremes.
  task automatic queue_random(input int count);
    pixel_t px;
    for (int i = 0; i < count; i++) begin
      px = $urandom;
      case ($urandom_range(0, 9))
        0: begin px.green = px.red; px.blue = px.red; end
        1: px.green = px.red;
        2: px.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: ;
      endcase
      if (px.red == px.green && px.green == px.blue) gray_seen++;
      pending_pixels.push_back(px);
    end
  endtask

  initial begin
    logic [hsa_pkg::GAIN_W-1:0] gains[6];
    gains = '{12'd0, 12'd4095, 12'd128, 12'd512, 12'd1, 12'd256};
    rst_n = 1'b0;
    idle_enable = 1'b1;
    sender_hold = 1'b0;
    in_pix.valid = 1'b0;
    in_pix.red = '0;
    in_pix.green = '0;
    in_pix.blue = '0;
    in_pix.alpha = '0;
    out_pix.ready = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.data = '0;
    gain_model = hsa_pkg::GAIN_RESET;
    mismatch_count = 0;
    pixels_sent = 0;
    pixels_checked = 0;
    gray_seen = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pixels at the reset gain: extremes, ties, grays, each sextant.
    pending_pixels.push_back({8'd0, 8'd0, 8'd0, 8'd0});
    pending_pixels.push_back({8'd255, 8'd255, 8'd255, 8'd255});
    pending_pixels.push_back({8'd128, 8'd128, 8'd128, 8'd77});
    pending_pixels.push_back({8'd255, 8'd0, 8'd0, 8'd255});
    pending_pixels.push_back({8'd0, 8'd255, 8'd0, 8'd1});
    pending_pixels.push_back({8'd0, 8'd0, 8'd255, 8'd2});
    pending_pixels.push_back({8'd255, 8'd255, 8'd0, 8'd3});
    pending_pixels.push_back({8'd0, 8'd255, 8'd255, 8'd4});
    pending_pixels.push_back({8'd255, 8'd0, 8'd255, 8'd5});
    pending_pixels.push_back({8'd200, 8'd100, 8'd50, 8'd6});
    pending_pixels.push_back({8'd200, 8'd50, 8'd100, 8'd7});
    pending_pixels.push_back({8'd100, 8'd200, 8'd50, 8'd8});
    pending_pixels.push_back({8'd50, 8'd200, 8'd100, 8'd9});
    pending_pixels.push_back({8'd50, 8'd100, 8'd200, 8'd10});
    pending_pixels.push_back({8'd100, 8'd50, 8'd200, 8'd11});
    pending_pixels.push_back({8'd1, 8'd0, 8'd0, 8'd170});
    pending_pixels.push_back({8'd255, 8'd254, 8'd254, 8'd85});
    wait_drained();

    // Directed extremes under every gain, then random runs.
    foreach (gains[k]) begin
      write_gain(gains[k]);
      pending_pixels.push_back({8'd255, 8'd1, 8'd0, 8'd0});
      pending_pixels.push_back({8'd10, 8'd20, 8'd30, 8'd255});
      pending_pixels.push_back({8'd7, 8'd7, 8'd7, 8'd7});
      queue_random(250);
      if (k == 2) begin
        // Let part of the batch go out, then hold the sender until the pipe is empty.
        repeat (100) @(posedge clk);
        sender_hold = 1'b1;
        while (expected_pixels.size() > 0 || in_pix.valid) @(posedge clk);
        sender_hold = 1'b0;
      end
    end
    write_gain(12'($urandom_range(0, 4095)));
    idle_enable = 1'b0;
    queue_random(200);
    wait_drained();

    $display("Sent %0d pixels, checked %0d results, %0d gray inputs, seven gain settings.",
             pixels_sent, pixels_checked, gray_seen);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("Mismatches: %0d", mismatch_count);
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timed out waiting for results.");
    $display("tb_top failed");
    $finish;
  end
endmodule
